[rtl/core/sohc_pkg.sv]
// Shared types, constants and a helper function for the servo open/hold/close
// sequencer. No dependencies; sohc_cfg, sohc_lane and the top level use this package.
`timescale 1ns / 1ps
`default_nettype none

package sohc_pkg;

  localparam int unsigned NUM_CH_MAX = 4;
  localparam int unsigned ANGLE_W    = 8;
  localparam int unsigned CFG_W      = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned MASK_W     = 8;
  localparam int unsigned TRAVEL_W   = 9;
  localparam int unsigned SLAVE_W    = 2;
  localparam int unsigned SUM_W      = 11;

  // Ease values are Q30 fractions; one is 2^30.
  localparam int unsigned Q_FRAC  = 30;
  localparam int unsigned EASE_W  = 31;
  localparam logic [EASE_W-1:0] EASE_ONE = 31'h4000_0000;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  localparam logic [ANGLE_W-1:0]  MAX_ANGLE = 8'd180;
  localparam logic [TRAVEL_W-1:0] OPEN_MS   = 9'd450;
  localparam logic [TRAVEL_W-1:0] CLOSE_MS  = 9'd500;

  localparam logic [ANGLE_W-1:0]       CENTER_RST = 8'd90;
  localparam logic signed [CFG_W-1:0]  DELTA_RST  = 9'sd45;
  localparam logic signed [CFG_W-1:0]  OFFSET_RST = 9'sd0;
  localparam logic [SLAVE_W-1:0]       SLAVE_RST  = 2'd0;
  // Closed angle with the reset center and a zero trim.
  localparam logic [ANGLE_W-1:0]       CLOSED_RST = 8'd90;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ADDR  = 2'd1,
    OP_BCAST = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_OPEN  = 2'd1,
    PH_HOLD  = 2'd2,
    PH_CLOSE = 2'd3
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER = 3'd0,
    REG_DELTA  = 3'd1,
    REG_OFF0   = 3'd2,
    REG_OFF1   = 3'd3,
    REG_OFF2   = 3'd4,
    REG_OFF3   = 3'd5,
    REG_SLAVE  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [MASK_W-1:0] servo_mask;
    logic [HOLD_W-1:0] hold_ms;
    logic [MASK_W-1:0] slave_mask_a;
    logic [MASK_W-1:0] slave_mask_b;
    logic [MASK_W-1:0] slave_mask_c;
    logic [MASK_W-1:0] slave_mask_d;
  } in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]    angle_ch0;
    logic [ANGLE_W-1:0]    angle_ch1;
    logic [ANGLE_W-1:0]    angle_ch2;
    logic [ANGLE_W-1:0]    angle_ch3;
    logic [NUM_CH_MAX-1:0] led_on_mask;
    logic [NUM_CH_MAX-1:0] busy_mask;
  } out_t;

  typedef struct packed {
    logic               tick;
    logic               start;
    logic [HOLD_W-1:0]  hold_ms;
    logic [ANGLE_W-1:0] open_angle;
    logic [ANGLE_W-1:0] closed_angle;
  } lane_ctl_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               led;
    logic               busy;
  } lane_sts_t;

  function automatic logic [ANGLE_W-1:0] clamp_angle(input logic signed [SUM_W-1:0] v);
    if (v < $signed(SUM_W'(0))) begin
      return '0;
    end else if (v > $signed(SUM_W'(MAX_ANGLE))) begin
      return MAX_ANGLE;
    end else begin
      return v[ANGLE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

[rtl/core/sohc_chan_if.sv]
// Valid/ready stream channel used for the item and result ports.
// Payload type is a parameter; the structs come from sohc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sohc_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/sohc_cfg.sv]
// Configuration register file and the per-channel open and closed angles
// derived from it. Depends on sohc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sohc_cfg (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [sohc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [sohc_pkg::CFG_W-1:0]             cfg_wdata_i,
  output logic [sohc_pkg::NUM_CH_MAX-1:0][sohc_pkg::ANGLE_W-1:0] open_angle_o,
  output logic [sohc_pkg::NUM_CH_MAX-1:0][sohc_pkg::ANGLE_W-1:0] closed_angle_o,
  output logic [sohc_pkg::SLAVE_W-1:0]                slave_id_o
);

  logic [sohc_pkg::ANGLE_W-1:0]      center_q;
  logic signed [sohc_pkg::CFG_W-1:0] delta_q;
  logic signed [sohc_pkg::CFG_W-1:0] off_q [sohc_pkg::NUM_CH_MAX];
  logic [sohc_pkg::SLAVE_W-1:0]      slave_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= sohc_pkg::CENTER_RST;
      delta_q  <= sohc_pkg::DELTA_RST;
      for (int i = 0; i < sohc_pkg::NUM_CH_MAX; i++) begin
        off_q[i] <= sohc_pkg::OFFSET_RST;
      end
      slave_q  <= sohc_pkg::SLAVE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sohc_pkg::REG_CENTER: center_q <= cfg_wdata_i[sohc_pkg::ANGLE_W-1:0];
        sohc_pkg::REG_DELTA:  delta_q  <= $signed(cfg_wdata_i);
        sohc_pkg::REG_OFF0:   off_q[0] <= $signed(cfg_wdata_i);
        sohc_pkg::REG_OFF1:   off_q[1] <= $signed(cfg_wdata_i);
        sohc_pkg::REG_OFF2:   off_q[2] <= $signed(cfg_wdata_i);
        sohc_pkg::REG_OFF3:   off_q[3] <= $signed(cfg_wdata_i);
        sohc_pkg::REG_SLAVE:  slave_q  <= cfg_wdata_i[sohc_pkg::SLAVE_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [sohc_pkg::SUM_W-1:0] center_s;
  logic signed [sohc_pkg::SUM_W-1:0] delta_s;
  logic signed [sohc_pkg::SUM_W-1:0] closed_sum [sohc_pkg::NUM_CH_MAX];
  logic signed [sohc_pkg::SUM_W-1:0] open_sum   [sohc_pkg::NUM_CH_MAX];

  always_comb begin
    center_s = $signed({3'b000, center_q});
    delta_s  = $signed({{2{delta_q[sohc_pkg::CFG_W-1]}}, delta_q});
    for (int i = 0; i < sohc_pkg::NUM_CH_MAX; i++) begin
      closed_sum[i] = center_s + $signed({{2{off_q[i][sohc_pkg::CFG_W-1]}}, off_q[i]});
      open_sum[i]   = closed_sum[i] + delta_s;
      closed_angle_o[i] = sohc_pkg::clamp_angle(closed_sum[i]);
      open_angle_o[i]   = sohc_pkg::clamp_angle(open_sum[i]);
    end
  end

  assign slave_id_o = slave_q;

endmodule

`default_nettype wire

[rtl/core/sohc_lane.sv]
// One servo channel: phase state, hold timer, incremental ease index and the
// eased angle update. Depends on sohc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sohc_lane #(
  parameter int unsigned EASE_STEPS = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire sohc_pkg::lane_ctl_t ctl_i,
  output sohc_pkg::lane_sts_t      sts_o,
  output sohc_pkg::lane_sts_t      nxt_o
);

  localparam int unsigned HALF = EASE_STEPS / 2;
  localparam int unsigned QW   = $clog2(EASE_STEPS + 1);
  localparam int unsigned HW   = $clog2(HALF + 1);
  localparam int unsigned SW   = $clog2(3 * 500 + EASE_STEPS);
  localparam int unsigned AW   = sohc_pkg::TRAVEL_W;
  localparam int unsigned PW   = sohc_pkg::ANGLE_W + sohc_pkg::EASE_W;

  typedef logic [sohc_pkg::EASE_W-1:0] ease_tbl_t [HALF+1];

  // First half of the cosine ease curve, 0.5*(1-cos(pi*u)), as a truncated
  // Taylor series in Q30. The second half is mirrored at lookup.
  function automatic ease_tbl_t build_ease();
    ease_tbl_t       tbl;
    longint unsigned x;
    longint unsigned y;
    longint unsigned t1;
    longint unsigned t2;
    longint unsigned t3;
    longint unsigned t4;
    longint unsigned t5;
    for (int k = 0; k <= HALF; k++) begin
      x  = (sohc_pkg::PI_Q30 * longint'(k)) / EASE_STEPS;
      y  = (x * x) >> 30;
      t1 = y / 2;
      t2 = ((t1 * y) >> 30) / 12;
      t3 = ((t2 * y) >> 30) / 30;
      t4 = ((t3 * y) >> 30) / 56;
      t5 = ((t4 * y) >> 30) / 90;
      tbl[k] = sohc_pkg::EASE_W'((t1 - t2 + t3 - t4 + t5) / 2);
    end
    return tbl;
  endfunction

  localparam ease_tbl_t EASE_TBL = build_ease();

  sohc_pkg::phase_e             phase_q, phase_d;
  logic [sohc_pkg::ANGLE_W-1:0] start_q, start_d;
  logic [sohc_pkg::ANGLE_W-1:0] tgt_q, tgt_d;
  logic [sohc_pkg::ANGLE_W-1:0] cur_q, cur_d;
  logic [sohc_pkg::HOLD_W-1:0]  el_q, el_d;
  logic [sohc_pkg::HOLD_W-1:0]  hold_q, hold_d;
  // acc_q and qc_q track elapsed*EASE_STEPS as quotient and remainder of the
  // travel time, so the ease index needs no divider.
  logic [AW-1:0]                acc_q, acc_d;
  logic [QW-1:0]                qc_q, qc_d;
  logic                         led_q, led_d;

  logic [sohc_pkg::TRAVEL_W-1:0] travel;
  logic [sohc_pkg::HOLD_W-1:0]   el_inc;
  logic [SW-1:0]                 acc_sum;
  logic [SW-1:0]                 trav_x1;
  logic [SW-1:0]                 trav_x2;
  logic [SW-1:0]                 trav_x3;
  logic [SW-1:0]                 acc_sub;
  logic [1:0]                    q_step;
  logic [AW-1:0]                 acc_n;
  logic [QW-1:0]                 q_n;
  logic                          mirror;
  logic [HW-1:0]                 hidx;
  logic [sohc_pkg::EASE_W-1:0]   ease;
  logic                          up;
  logic [sohc_pkg::ANGLE_W-1:0]  mag;
  logic [PW-1:0]                 prod;
  logic [PW-1:0]                 rnd;
  logic [sohc_pkg::ANGLE_W-1:0]  step;
  logic signed [sohc_pkg::SUM_W-1:0] pos;
  logic [sohc_pkg::ANGLE_W-1:0]  ang_ease;

  always_comb begin
    travel = (phase_q == sohc_pkg::PH_OPEN) ? sohc_pkg::OPEN_MS : sohc_pkg::CLOSE_MS;
    el_inc = (el_q == '1) ? el_q : el_q + sohc_pkg::HOLD_W'(1);

    acc_sum = SW'(acc_q) + SW'(EASE_STEPS);
    trav_x1 = SW'(travel);
    trav_x2 = SW'({travel, 1'b0});
    trav_x3 = trav_x1 + trav_x2;
    if (acc_sum >= trav_x3) begin
      q_step  = 2'd3;
      acc_sub = trav_x3;
    end else if (acc_sum >= trav_x2) begin
      q_step  = 2'd2;
      acc_sub = trav_x2;
    end else if (acc_sum >= trav_x1) begin
      q_step  = 2'd1;
      acc_sub = trav_x1;
    end else begin
      q_step  = 2'd0;
      acc_sub = '0;
    end
    acc_n = AW'(acc_sum - acc_sub);
    q_n   = qc_q + QW'(q_step);

    mirror = ({1'b0, q_n} << 1) > (QW + 1)'(EASE_STEPS);
    hidx   = mirror ? HW'(QW'(EASE_STEPS) - q_n) : HW'(q_n);
    ease   = mirror ? (sohc_pkg::EASE_ONE - EASE_TBL[hidx]) : EASE_TBL[hidx];

    up   = (tgt_q >= start_q);
    mag  = up ? (tgt_q - start_q) : (start_q - tgt_q);
    prod = PW'(mag) * PW'(ease);
    rnd  = prod + (PW'(1) << (sohc_pkg::Q_FRAC - 1));
    step = rnd[sohc_pkg::Q_FRAC +: sohc_pkg::ANGLE_W];
    pos  = up ? ($signed({3'b000, start_q}) + $signed({3'b000, step}))
              : ($signed({3'b000, start_q}) - $signed({3'b000, step}));
    ang_ease = sohc_pkg::clamp_angle(pos);
  end

  always_comb begin
    phase_d = phase_q;
    start_d = start_q;
    tgt_d   = tgt_q;
    cur_d   = cur_q;
    el_d    = el_q;
    hold_d  = hold_q;
    acc_d   = acc_q;
    qc_d    = qc_q;
    led_d   = led_q;
    if (ctl_i.start) begin
      start_d = cur_q;
      tgt_d   = ctl_i.open_angle;
      el_d    = '0;
      hold_d  = ctl_i.hold_ms;
      acc_d   = '0;
      qc_d    = '0;
      phase_d = sohc_pkg::PH_OPEN;
      led_d   = 1'b1;
    end else if (ctl_i.tick) begin
      case (phase_q)
        sohc_pkg::PH_OPEN, sohc_pkg::PH_CLOSE: begin
          if (el_inc >= sohc_pkg::HOLD_W'(travel)) begin
            cur_d = tgt_q;
            el_d  = '0;
            acc_d = '0;
            qc_d  = '0;
            if (phase_q == sohc_pkg::PH_OPEN) begin
              phase_d = sohc_pkg::PH_HOLD;
            end else begin
              phase_d = sohc_pkg::PH_IDLE;
              led_d   = 1'b0;
            end
          end else begin
            el_d  = el_inc;
            acc_d = acc_n;
            qc_d  = q_n;
            cur_d = ang_ease;
          end
        end
        sohc_pkg::PH_HOLD: begin
          // The angle stays put on the tick that ends the hold.
          if (el_inc >= hold_q) begin
            phase_d = sohc_pkg::PH_CLOSE;
            start_d = cur_q;
            tgt_d   = ctl_i.closed_angle;
            el_d    = '0;
            acc_d   = '0;
            qc_d    = '0;
          end else begin
            el_d = el_inc;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sohc_pkg::PH_IDLE;
      start_q <= sohc_pkg::CLOSED_RST;
      tgt_q   <= sohc_pkg::CLOSED_RST;
      cur_q   <= sohc_pkg::CLOSED_RST;
      el_q    <= '0;
      hold_q  <= '0;
      acc_q   <= '0;
      qc_q    <= '0;
      led_q   <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      start_q <= start_d;
      tgt_q   <= tgt_d;
      cur_q   <= cur_d;
      el_q    <= el_d;
      hold_q  <= hold_d;
      acc_q   <= acc_d;
      qc_q    <= qc_d;
      led_q   <= led_d;
    end
  end

  always_comb begin
    sts_o.angle = cur_q;
    sts_o.led   = led_q;
    sts_o.busy  = (phase_q != sohc_pkg::PH_IDLE);
    nxt_o.angle = cur_d;
    nxt_o.led   = led_d;
    nxt_o.busy  = (phase_d != sohc_pkg::PH_IDLE);
  end

endmodule

`default_nettype wire

[rtl/core/servo_open_hold_close_sequencer_unit.sv]
// Top level of the servo open/hold/close sequencer: command decode, channel
// lanes, configuration registers and the result register.
// Depends on sohc_pkg, sohc_chan_if, sohc_cfg and sohc_lane.
//
//   port     dir  kind         payload
//   in_i     in   valid/ready  sohc_pkg::in_t  (opcode, masks, hold time)
//   out_o    out  valid/ready  sohc_pkg::out_t (angles, LED and busy masks)
//   cfg_*    in   write only   register index and 9-bit data
//
// One item per clock while in_i is ready: each lane updates its state with one ease
// table lookup and one 8x31 multiply, and each item yields one result.
// After reset every channel is idle at the closed angle of the reset
// configuration (90 degrees); there is no clearing pass.
// The channel state itself holds one finished result besides the result
// register, so input stalls only when both are full and out_o is stalled.
`timescale 1ns / 1ps
`default_nettype none

module servo_open_hold_close_sequencer_unit #(
  parameter int unsigned NUM_CHANNELS = 4,
  parameter int unsigned EASE_STEPS   = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [sohc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [sohc_pkg::CFG_W-1:0]       cfg_wdata_i,
  sohc_chan_if.sink                             in_i,
  sohc_chan_if.source                           out_o
);

  logic [sohc_pkg::NUM_CH_MAX-1:0][sohc_pkg::ANGLE_W-1:0] open_angle;
  logic [sohc_pkg::NUM_CH_MAX-1:0][sohc_pkg::ANGLE_W-1:0] closed_angle;
  logic [sohc_pkg::SLAVE_W-1:0]                           slave_id;

  sohc_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .open_angle_o   (open_angle),
    .closed_angle_o (closed_angle),
    .slave_id_o     (slave_id)
  );

  sohc_pkg::in_t                in_data;
  logic                         accept;
  logic                         is_tick;
  logic [sohc_pkg::MASK_W-1:0]  start_mask;

  assign in_data = in_i.data;
  assign accept  = in_i.valid && in_i.ready;

  always_comb begin
    is_tick    = (in_data.opcode == sohc_pkg::OP_TICK);
    start_mask = '0;
    case (in_data.opcode)
      sohc_pkg::OP_ADDR: start_mask = in_data.servo_mask;
      sohc_pkg::OP_BCAST: begin
        case (slave_id)
          2'd0:    start_mask = in_data.slave_mask_a;
          2'd1:    start_mask = in_data.slave_mask_b;
          2'd2:    start_mask = in_data.slave_mask_c;
          default: start_mask = in_data.slave_mask_d;
        endcase
      end
      default: start_mask = '0;
    endcase
  end

  sohc_pkg::lane_sts_t sts_cur [sohc_pkg::NUM_CH_MAX];
  sohc_pkg::lane_sts_t sts_nxt [sohc_pkg::NUM_CH_MAX];

  for (genvar ch = 0; ch < sohc_pkg::NUM_CH_MAX; ch++) begin : g_lane
    if (ch < NUM_CHANNELS) begin : g_used
      sohc_pkg::lane_ctl_t ctl;
      always_comb begin
        ctl.tick         = is_tick;
        ctl.start        = start_mask[ch];
        ctl.hold_ms      = in_data.hold_ms;
        ctl.open_angle   = open_angle[ch];
        ctl.closed_angle = closed_angle[ch];
      end
      sohc_lane #(
        .EASE_STEPS (EASE_STEPS)
      ) u_lane (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (accept),
        .ctl_i  (ctl),
        .sts_o  (sts_cur[ch]),
        .nxt_o  (sts_nxt[ch])
      );
    end else begin : g_unused
      assign sts_cur[ch] = '0;
      assign sts_nxt[ch] = '0;
    end
  end

  sohc_pkg::out_t cur_res;
  sohc_pkg::out_t nxt_res;

  always_comb begin
    cur_res.angle_ch0 = sts_cur[0].angle;
    cur_res.angle_ch1 = sts_cur[1].angle;
    cur_res.angle_ch2 = sts_cur[2].angle;
    cur_res.angle_ch3 = sts_cur[3].angle;
    nxt_res.angle_ch0 = sts_nxt[0].angle;
    nxt_res.angle_ch1 = sts_nxt[1].angle;
    nxt_res.angle_ch2 = sts_nxt[2].angle;
    nxt_res.angle_ch3 = sts_nxt[3].angle;
    for (int i = 0; i < sohc_pkg::NUM_CH_MAX; i++) begin
      cur_res.led_on_mask[i] = sts_cur[i].led;
      cur_res.busy_mask[i]   = sts_cur[i].busy;
      nxt_res.led_on_mask[i] = sts_nxt[i].led;
      nxt_res.busy_mask[i]   = sts_nxt[i].busy;
    end
  end

  // pend_q: the lane state holds a result that has not yet moved to the
  // result register.
  logic           out_valid_q, out_valid_d;
  logic           pend_q, pend_d;
  sohc_pkg::out_t out_data_q, out_data_d;
  logic           slot_free;
  logic           load_out;

  assign slot_free   = !out_valid_q || out_o.ready;
  assign in_i.ready  = !pend_q || slot_free;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    pend_d      = pend_q;
    out_data_d  = out_data_q;
    load_out    = 1'b0;
    if (pend_q && slot_free) begin
      // Move the held result out; a transfer in the same cycle becomes the
      // next held result.
      load_out    = 1'b1;
      out_data_d  = cur_res;
      out_valid_d = 1'b1;
      pend_d      = accept;
    end else if (accept && slot_free) begin
      load_out    = 1'b1;
      out_data_d  = nxt_res;
      out_valid_d = 1'b1;
    end else if (accept) begin
      pend_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= out_data_d;
    end
  end

  a_pend_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q)
    else $error("held result without a valid result register");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !pend_q && slot_free) |=> (out_valid_q && !pend_q))
    else $error("accepted item did not reach the result register");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.angle_ch0 <= sohc_pkg::MAX_ANGLE &&
                     out_data_q.angle_ch1 <= sohc_pkg::MAX_ANGLE &&
                     out_data_q.angle_ch2 <= sohc_pkg::MAX_ANGLE &&
                     out_data_q.angle_ch3 <= sohc_pkg::MAX_ANGLE))
    else $error("angle above maximum");

  a_led_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_res.led_on_mask & ~cur_res.busy_mask) == '0)
    else $error("LED lit on an idle channel");

endmodule

`default_nettype wire

[tb/servo_open_hold_close_sequencer_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for the servo open/hold/close sequencer: random ticks and commands
// under several register settings, each result checked against a cycle-free predictor.
// Depends on sohc_pkg, sohc_chan_if and servo_open_hold_close_sequencer_unit.

module servo_open_hold_close_sequencer_unit_test;
  import sohc_pkg::*;

  localparam int NUM_CHANNELS  = 4;
  localparam int EASE_STEPS    = 256;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLDOFF  = 60;
  localparam int MAX_REPORTS   = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  sohc_chan_if #(.T(in_t))  item_ch ();
  sohc_chan_if #(.T(out_t)) frame_ch ();

  servo_open_hold_close_sequencer_unit #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .EASE_STEPS  (EASE_STEPS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (item_ch),
    .out_o      (frame_ch)
  );

  // Tracks channel phases, angles and LEDs, and holds the frames still owed by the block.
  class servo_frame_checker;
    out_t        expected_frames[$];
    int          mismatches;
    int          frames_seen;
    logic [7:0]  center;
    int          delta;
    int          trim[NUM_CHANNELS];
    logic [1:0]  slave;
    phase_e      ph[NUM_CHANNELS];
    logic [7:0]  from_ang[NUM_CHANNELS];
    logic [7:0]  to_ang[NUM_CHANNELS];
    logic [7:0]  ang[NUM_CHANNELS];
    logic [15:0] ms[NUM_CHANNELS];
    logic [15:0] hold_len[NUM_CHANNELS];
    logic [3:0]  led;

    function new();
      mismatches  = 0;
      frames_seen = 0;
      center      = CENTER_RST;
      delta       = int'(DELTA_RST);
      slave       = SLAVE_RST;
      led         = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        trim[i] = int'(OFFSET_RST);
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        ph[i]       = PH_IDLE;
        ang[i]      = closed_angle(i);
        from_ang[i] = ang[i];
        to_ang[i]   = ang[i];
        ms[i]       = '0;
        hold_len[i] = '0;
      end
    endfunction

    function logic [7:0] fit_angle(int v);
      if (v < 0) return 8'd0;
      if (v > int'(MAX_ANGLE)) return MAX_ANGLE;
      return v[7:0];
    endfunction

    function logic [7:0] closed_angle(int i);
      return fit_angle(int'(center) + trim[i]);
    endfunction

    function logic [7:0] open_angle(int i);
      return fit_angle(int'(center) + trim[i] + delta);
    endfunction

    // Lower half of 0.5*(1-cos(pi*u)) from a truncated Taylor series in Q30.
    function longint unsigned ease_lower(longint unsigned q);
      longint unsigned x, y, t1, t2, t3, t4, t5;
      x  = (PI_Q30 * q) / longint'(EASE_STEPS);
      y  = (x * x) >> 30;
      t1 = y / 2;
      t2 = ((t1 * y) >> 30) / 12;
      t3 = ((t2 * y) >> 30) / 30;
      t4 = ((t3 * y) >> 30) / 56;
      t5 = ((t4 * y) >> 30) / 90;
      return (t1 - t2 + t3 - t4 + t5) / 2;
    endfunction

    function longint unsigned ease_value(longint unsigned q);
      longint unsigned steps;
      steps = longint'(EASE_STEPS);
      if (q > steps) q = steps;
      if (2 * q > steps) return (64'd1 << 30) - ease_lower(steps - q);
      return ease_lower(q);
    endfunction

    function logic [7:0] eased_angle(int i, int travel);
      longint unsigned step_q, e, mag;
      int diff, r;
      step_q = (longint'(ms[i]) * longint'(EASE_STEPS)) / longint'(travel);
      e      = ease_value(step_q);
      diff   = int'(to_ang[i]) - int'(from_ang[i]);
      mag    = (diff < 0) ? -diff : diff;
      r      = int'((mag * e + (64'd1 << 29)) >> 30);
      return fit_angle(int'(from_ang[i]) + ((diff < 0) ? -r : r));
    endfunction

    function void advance_ms();
      int travel;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (ph[i] == PH_OPEN || ph[i] == PH_CLOSE) begin
          travel = (ph[i] == PH_OPEN) ? int'(OPEN_MS) : int'(CLOSE_MS);
          if (ms[i] != 16'hFFFF) ms[i]++;
          if (int'(ms[i]) >= travel) begin
            ang[i] = to_ang[i];
            ms[i]  = '0;
            if (ph[i] == PH_OPEN) begin
              ph[i] = PH_HOLD;
            end else begin
              ph[i]  = PH_IDLE;
              led[i] = 1'b0;
            end
          end else begin
            ang[i] = eased_angle(i, travel);
          end
        end else if (ph[i] == PH_HOLD) begin
          if (ms[i] != 16'hFFFF) ms[i]++;
          // The closing move starts from wherever the channel stands now.
          if (ms[i] >= hold_len[i]) begin
            ph[i]       = PH_CLOSE;
            from_ang[i] = ang[i];
            to_ang[i]   = closed_angle(i);
            ms[i]       = '0;
          end
        end
      end
    endfunction

    function void start_channels(logic [7:0] mask, logic [15:0] hold);
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (mask[i]) begin
          from_ang[i] = ang[i];
          to_ang[i]   = open_angle(i);
          ms[i]       = '0;
          hold_len[i] = hold;
          ph[i]       = PH_OPEN;
          led[i]      = 1'b1;
        end
      end
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_CENTER: center  = v[7:0];
        REG_DELTA:  delta   = int'($signed(v));
        REG_OFF0:   trim[0] = int'($signed(v));
        REG_OFF1:   trim[1] = int'($signed(v));
        REG_OFF2:   trim[2] = int'($signed(v));
        REG_OFF3:   trim[3] = int'($signed(v));
        REG_SLAVE:  slave   = v[1:0];
        default: ;
      endcase
    endfunction

    function void apply_item(in_t it);
      logic [7:0] picked;
      out_t f;
      case (it.opcode)
        OP_TICK: advance_ms();
        OP_ADDR: start_channels(it.servo_mask, it.hold_ms);
        OP_BCAST: begin
          case (slave)
            2'd0:    picked = it.slave_mask_a;
            2'd1:    picked = it.slave_mask_b;
            2'd2:    picked = it.slave_mask_c;
            default: picked = it.slave_mask_d;
          endcase
          if (picked != 8'h00) start_channels(picked, it.hold_ms);
        end
        default: ;
      endcase
      f.angle_ch0   = ang[0];
      f.angle_ch1   = ang[1];
      f.angle_ch2   = ang[2];
      f.angle_ch3   = ang[3];
      f.led_on_mask = led;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        f.busy_mask[i] = (ph[i] != PH_IDLE);
      end
      expected_frames.push_back(f);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch in %s of result %0d: expected %0d, got %0d",
                   name, frames_seen, want, got);
        end
      end
    endfunction

    function void compare_frame(out_t got);
      out_t want;
      frames_seen++;
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result %0d arrived with nothing expected", frames_seen);
        end
        return;
      end
      want = expected_frames.pop_front();
      check_field("angle_ch0", want.angle_ch0, got.angle_ch0);
      check_field("angle_ch1", want.angle_ch1, got.angle_ch1);
      check_field("angle_ch2", want.angle_ch2, got.angle_ch2);
      check_field("angle_ch3", want.angle_ch3, got.angle_ch3);
      check_field("led_on_mask", 8'(want.led_on_mask), 8'(got.led_on_mask));
      check_field("busy_mask", 8'(want.busy_mask), 8'(got.busy_mask));
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    function int failures();
      return mismatches + expected_frames.size();
    endfunction
  endclass

  servo_frame_checker sb;
  int result_holdoff;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Both directions are observed at the rising edge, before the block updates.
  always @(posedge clk_i) begin
    if (rst_ni && item_ch.valid && item_ch.ready) sb.apply_item(item_ch.data);
    if (rst_ni && frame_ch.valid && frame_ch.ready) sb.compare_frame(frame_ch.data);
  end

  // Result side: changes its stall style now and then, and obeys long holdoff requests.
  initial begin
    int cyc;
    int style;
    cyc   = 0;
    style = 0;
    frame_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (result_holdoff > 0) begin
        frame_ch.ready <= 1'b0;
        repeat (result_holdoff) @(negedge clk_i);
        result_holdoff = 0;
      end
      cyc++;
      if (cyc % 97 == 0) style = $urandom_range(0, 3);
      case (style)
        0:       frame_ch.ready <= 1'b1;
        1:       frame_ch.ready <= 1'($urandom_range(0, 1));
        2:       frame_ch.ready <= ($urandom_range(0, 3) == 0);
        default: frame_ch.ready <= ((cyc / 5) % 3 != 0);
      endcase
    end
  end

  initial begin
    #10ms;
    $display("FAIL servo_open_hold_close_sequencer_unit");
    $finish;
  end

  function automatic in_t make_item(opcode_e op, logic [7:0] mask, logic [15:0] hold);
    logic [63:0] r;
    in_t it;
    r  = {$urandom, $urandom};
    it = r[$bits(in_t)-1:0];
    it.opcode  = op;
    it.hold_ms = hold;
    if (op == OP_ADDR) begin
      it.servo_mask = mask;
    end else if (op == OP_BCAST) begin
      case (sb.slave)
        2'd0:    it.slave_mask_a = mask;
        2'd1:    it.slave_mask_b = mask;
        2'd2:    it.slave_mask_c = mask;
        default: it.slave_mask_d = mask;
      endcase
    end
    return it;
  endfunction

  function automatic logic [15:0] random_hold();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return 16'($urandom_range(0, 30));
    if (pick < 9) return 16'($urandom_range(0, 700));
    return 16'($urandom);
  endfunction

  // Mostly ticks so that motions run to completion; commands and no-ops are rare.
  function automatic in_t random_item(int cmd_permille);
    int roll;
    logic [7:0] mask;
    roll = $urandom_range(0, 999);
    mask = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
    if (roll < cmd_permille) begin
      if ($urandom_range(0, 1) != 0) return make_item(OP_ADDR, mask, random_hold());
      return make_item(OP_BCAST, mask, random_hold());
    end
    if (roll < cmd_permille + 8) return make_item(OP_NOP, mask, 16'($urandom));
    return make_item(OP_TICK, mask, 16'($urandom));
  endfunction

  task automatic offer(input in_t it);
    @(negedge clk_i);
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk_i); while (!item_ch.ready);
  endtask

  task automatic idle_sender(input int n);
    @(negedge clk_i);
    item_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic send_items(input int count, input int cmd_permille);
    int burst_left;
    int gap;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      // Stall the result side while items keep coming, so the block backs up.
      if (i == count / 3) begin
        result_holdoff = LONG_HOLDOFF;
        burst_left     = 40;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) idle_sender(gap);
      end
      offer(random_item(cmd_permille));
      burst_left--;
    end
  endtask

  task automatic drain_results();
    idle_sender(1);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    sb.set_register(idx, v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] center, input logic [CFG_W-1:0] delta,
                               input logic [CFG_W-1:0] o0, input logic [CFG_W-1:0] o1,
                               input logic [CFG_W-1:0] o2, input logic [CFG_W-1:0] o3,
                               input logic [CFG_W-1:0] slave);
    write_reg(REG_CENTER, center);
    write_reg(REG_DELTA, delta);
    write_reg(REG_OFF0, o0);
    write_reg(REG_OFF1, o1);
    write_reg(REG_OFF2, o2);
    write_reg(REG_OFF3, o3);
    write_reg(REG_SLAVE, slave);
    // An index past the last register must not disturb anything.
    write_reg(REG_SPARE, 9'($urandom));
  endtask

  task automatic run_directed();
    in_t it;
    it = '1;
    offer(it);
    offer(make_item(OP_TICK, 8'h00, 16'h0000));
    offer(make_item(OP_ADDR, 8'h00, 16'h0000));
    // Only mask bits above the channel count are set.
    offer(make_item(OP_ADDR, 8'hF0, 16'hFFFF));
    it = make_item(OP_BCAST, 8'h00, 16'h1234);
    it.slave_mask_b = 8'hFF;
    it.slave_mask_c = 8'hFF;
    it.slave_mask_d = 8'hFF;
    offer(it);
    offer(make_item(OP_ADDR, 8'h01, 16'h0000));
    offer(make_item(OP_BCAST, 8'h0E, 16'hFFFF));
    repeat (6) offer(make_item(OP_TICK, 8'hFF, 16'hFFFF));
    // Restart every channel while it is still moving.
    offer(make_item(OP_ADDR, 8'hFF, 16'd2));
    repeat (4) offer(make_item(OP_TICK, 8'h00, 16'h0000));
    idle_sender(3);
    offer(make_item(OP_NOP, 8'h00, 16'h0000));
  endtask

  initial begin
    sb             = new();
    result_holdoff = 0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    item_ch.valid  = 1'b0;
    item_ch.data   = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    // Zero hold on all channels, then long enough to open, hold, close and go idle.
    offer(make_item(OP_ADDR, 8'h0F, 16'h0000));
    send_items(1000, 1);
    drain_results();

    load_settings(9'h000, 9'h14C, 9'h14C, 9'h000, 9'h0B4, 9'h1FF, 9'h001);
    send_items(80, 40);
    drain_results();

    load_settings(9'h0B4, 9'h0B4, 9'h000, 9'h0B4, 9'h14C, 9'h001, 9'h002);
    send_items(80, 40);
    drain_results();

    load_settings(9'h1FF, 9'h100, 9'h0FF, 9'h100, 9'($urandom), 9'($urandom), 9'h1FF);
    send_items(80, 40);
    drain_results();

    repeat (2) begin
      load_settings(9'($urandom_range(0, 180)), 9'($urandom_range(0, 360) - 180),
                    9'($urandom_range(0, 360) - 180), 9'($urandom_range(0, 360) - 180),
                    9'($urandom_range(0, 360) - 180), 9'($urandom_range(0, 360) - 180),
                    9'($urandom_range(0, 3)));
      send_items(80, 40);
      drain_results();
    end

    if (sb.failures() == 0) begin
      $display("PASS servo_open_hold_close_sequencer_unit");
    end else begin
      $display("FAIL servo_open_hold_close_sequencer_unit");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/sohc_pkg.sv
rtl/core/sohc_chan_if.sv
rtl/core/sohc_cfg.sv
rtl/core/sohc_lane.sv
rtl/core/servo_open_hold_close_sequencer_unit.sv
tb/servo_open_hold_close_sequencer_unit_test.sv
